// File: rtl/ibs_pkg.sv
// shared types and constants for the integer block sorter
`timescale 1ns / 1ps

package ibs_pkg;

  localparam int unsigned WORD_W = 32;

  // one input word: a value of the block and the end-of-block flag
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     last_item;
  } ibs_in_t;

  // one output word: the next value in ascending order and the final flag
  typedef struct packed {
    logic signed [WORD_W-1:0] sorted_value;
    logic                     last_out;
  } ibs_out_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } ibs_ctrl_t;

endpackage

// File: rtl/ibs_cell.sv
// one cell of the insertion chain: holds one value and its valid bit
`timescale 1ns / 1ps

module ibs_cell
  import ibs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ibs_ctrl_t                ctrl_i,
  input  logic signed [WORD_W-1:0] new_value_i,
  input  logic                     prev_gt_i,
  input  logic signed [WORD_W-1:0] prev_value_i,
  input  logic                     prev_valid_i,
  input  logic signed [WORD_W-1:0] next_value_i,
  input  logic                     next_valid_i,
  output logic                     gt_o,
  output logic signed [WORD_W-1:0] value_o,
  output logic                     valid_o
);

  logic signed [WORD_W-1:0] value_q, value_d;
  logic                     valid_q, valid_d;

  // an empty cell counts as larger than any value
  assign gt_o = !valid_q || (value_q > new_value_i);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end else if (ctrl_i.insert && gt_o) begin
      // the insert point takes the new value, cells above it move up one
      if (prev_gt_i) begin
        value_d = prev_value_i;
        valid_d = prev_valid_i;
      end else begin
        value_d = new_value_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// File: rtl/integer_block_sorter.sv
// top level of the integer block sorter: insertion chain, load/drain control, output register
`timescale 1ns / 1ps
//
// usage
// - input channel (in_valid_i / in_stall_o / in_data_i): one signed 32-bit word per
//   cycle while loading; the word with last_item set closes the block
// - each word is placed into the ascending chain in the cycle it is accepted, so
//   loading runs at one word per cycle
// - words beyond BLOCK_SIZE in one block are dropped, the last_item flag still
//   closes the block
// - after the closing word the input stalls and the chain drains through cell 0,
//   one word per cycle into the output register while it is free; the first sorted
//   word shows once drain_q is set and cell 0 has moved into the output register
// - output channel (out_valid_o / out_stall_i / out_data_o): ascending order, last_out
//   on the largest value; a stalled word holds and the drain pauses with it
// - input resumes in the same cycle as the final word shows in the output register
// - reset clears all cell valid bits, the count and the output valid; no clearing
//   pass is needed
//
module integer_block_sorter
  import ibs_pkg::*;
#(
  parameter int unsigned BLOCK_SIZE = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ibs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ibs_out_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(BLOCK_SIZE + 1);

  // chain wiring, one entry per cell
  logic                     cell_gt    [BLOCK_SIZE];
  logic signed [WORD_W-1:0] cell_value [BLOCK_SIZE];
  logic                     cell_valid [BLOCK_SIZE];

  logic [CNT_W-1:0] count_q, count_d;
  logic             drain_q, drain_d;
  logic             out_valid_q, out_valid_d;
  ibs_out_t         out_data_q, out_data_d;

  ibs_ctrl_t ctrl;
  logic      in_fire;
  logic      full;
  logic      pop;

  assign in_fire = in_valid_i && !in_stall_o;
  assign full    = (count_q == CNT_W'(BLOCK_SIZE));
  // while draining, move the head of the chain out whenever the output register is free
  assign pop     = drain_q && (!out_valid_q || !out_stall_i);

  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = pop;

  // row of cells, cell 0 holds the smallest value
  for (genvar i = 0; i < BLOCK_SIZE; i++) begin : g_cell
    logic                     prev_gt;
    logic signed [WORD_W-1:0] prev_value;
    logic                     prev_valid;
    logic signed [WORD_W-1:0] next_value;
    logic                     next_valid;

    if (i == 0) begin : g_head
      assign prev_gt    = 1'b0;
      assign prev_value = in_data_i.value;
      assign prev_valid = 1'b0;
    end else begin : g_body
      assign prev_gt    = cell_gt[i-1];
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    if (i == BLOCK_SIZE - 1) begin : g_tail
      // the top cell empties as the chain drains
      assign next_value = cell_value[i];
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    ibs_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_value_i  (in_data_i.value),
      .prev_gt_i    (prev_gt),
      .prev_value_i (prev_value),
      .prev_valid_i (prev_valid),
      .next_value_i (next_value),
      .next_valid_i (next_valid),
      .gt_o         (cell_gt[i]),
      .value_o      (cell_value[i]),
      .valid_o      (cell_valid[i])
    );
  end

  // load/drain control and held count
  always_comb begin
    count_d = count_q;
    drain_d = drain_q;
    if (pop) begin
      count_d = count_q - CNT_W'(1);
      if (count_q == CNT_W'(1)) begin
        drain_d = 1'b0;
      end
    end else if (in_fire) begin
      if (!full) begin
        count_d = count_q + CNT_W'(1);
      end
      if (in_data_i.last_item) begin
        drain_d = 1'b1;
      end
    end
  end

  // output register, holds while the receiver stalls
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (pop) begin
      out_valid_d             = 1'b1;
      out_data_d.sorted_value = cell_value[0];
      out_data_d.last_out     = (count_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drain_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = drain_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/ibs_checker.sv
// port-level assertions for the integer block sorter, bound to the top level
`timescale 1ns / 1ps

module ibs_checker
  import ibs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input ibs_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input ibs_out_t out_data_o
);

  // a stalled output word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  // input stalls only after a closing word was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o && in_data_i.last_item))
    else $error("input stalled without a closing word");

  // nothing comes out unless a block is draining or a word is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("output word without a draining block");

  // a non-final word means the block is still draining
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_out |-> in_stall_o)
    else $error("input open while block words remain");

endmodule

bind integer_block_sorter ibs_checker u_ibs_checker (.*);
